[src/tlse_pkg.sv]
// Shared types and constants of the thick line segment extruder.
`timescale 1ns / 1ps
`default_nettype none
package tlse_pkg;
    localparam int COORD_W    = 32;
    localparam int WIDTH_W    = 23;
    localparam int STEP_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = 2'd1;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET  = 23'd3277;
    localparam logic [STEP_W-1:0]  SAMPLE_STEP_RESET = 31'd655;

    // square root: 32 result bits, two per stage
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = 16;
    localparam int LEN_W     = 32;
    localparam int RAD_W     = 63;

    // division: 24 quotient bits, three per stage
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = 8;
    localparam int QUO_W      = 24;
    localparam int NUM_W      = 55;
    localparam int DEN_W      = 33;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      dpos;
        logic                      zero;
        logic                      endm;
        logic [STEP_W-1:0]         a;
        logic [STEP_W-1:0]         b;
    } side_t;

    typedef struct packed {
        logic adv;
    } pipe_ctl_t;
endpackage
`default_nettype wire

[src/tlse_sqrt.sv]
// Pipelined floor square root, two result bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module tlse_sqrt (
    input  wire                      clk,
    input  wire tlse_pkg::pipe_ctl_t ctl,
    input  wire [tlse_pkg::RAD_W-1:0] radicand,
    output logic [tlse_pkg::LEN_W-1:0] root
);
    import tlse_pkg::*;

    logic [63:0] rem_reg  [SQ_STAGES];
    logic [63:0] rt_reg   [SQ_STAGES];
    logic [63:0] rem_next [SQ_STAGES];
    logic [63:0] rt_next  [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        localparam int PREV = (s > 0) ? s - 1 : 0;

        always_comb
        begin
            logic [63:0] rem;
            logic [63:0] rt;
            logic [63:0] bitv;
            if (s == 0)
            begin
                rem = {1'b0, radicand};
                rt  = '0;
            end
            else
            begin
                rem = rem_reg[PREV];
                rt  = rt_reg[PREV];
            end
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                bitv = 64'd1 << (2 * (LEN_W - 1 - s * SQ_STEPS - k));
                if (rem >= rt + bitv)
                begin
                    rem = rem - (rt + bitv);
                    rt  = (rt >> 1) + bitv;
                end
                else
                begin
                    rt = rt >> 1;
                end
            end
            rem_next[s] = rem;
            rt_next[s]  = rt;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[s] <= rem_next[s];
                rt_reg[s]  <= rt_next[s];
            end
        end
    end

    assign root = rt_reg[SQ_STAGES-1][LEN_W-1:0];
endmodule
`default_nettype wire

[src/tlse_div.sv]
// Pipelined restoring divider, three quotient bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module tlse_div (
    input  wire                        clk,
    input  wire tlse_pkg::pipe_ctl_t   ctl,
    input  wire [tlse_pkg::NUM_W-1:0]  numer,
    input  wire [tlse_pkg::DEN_W-1:0]  denom,
    output logic [tlse_pkg::QUO_W-1:0] quot
);
    import tlse_pkg::*;

    localparam int REM_W = DEN_W + QUO_W;

    logic [REM_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [REM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int PREV = (s > 0) ? s - 1 : 0;

        always_comb
        begin
            logic [REM_W-1:0] rem;
            logic [QUO_W-1:0] q;
            logic [DEN_W-1:0] d;
            logic [REM_W-1:0] trial;
            int               pos;
            if (s == 0)
            begin
                rem = REM_W'(numer);
                q   = '0;
                d   = denom;
            end
            else
            begin
                rem = rem_reg[PREV];
                q   = quo_reg[PREV];
                d   = den_reg[PREV];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                pos   = QUO_W - 1 - s * DIV_STEPS - k;
                trial = REM_W'(d) << pos;
                if (rem >= trial)
                begin
                    rem    = rem - trial;
                    q[pos] = 1'b1;
                end
            end
            rem_next[s] = rem;
            quo_next[s] = q;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= (s == 0) ? denom : den_reg[PREV];
            end
        end
    end

    assign quot = quo_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

[src/thick_line_segment_extrude.sv]
// Top level: extrudes one plotted sample into the two stroke vertices.
//
// channel  | dir | handshake               | payload
// sample   | in  | sample_valid/_stall     | x_pos, y_here, y_next, end_of_plot
// result   | out | result_valid/_stall     | upper_x/y, lower_x/y, saturated, end_out
// cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled. Stages: 1 to 4, square root
// pipeline, M, A, divider pipeline, output registers. All stages advance together;
// a stalled result freezes the whole pipeline and raises sample_stall.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module thick_line_segment_extrude (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                sample_valid,
    output logic                               sample_stall,
    input  wire signed [tlse_pkg::COORD_W-1:0] x_pos,
    input  wire signed [tlse_pkg::COORD_W-1:0] y_here,
    input  wire signed [tlse_pkg::COORD_W-1:0] y_next,
    input  wire                                end_of_plot,
    output logic                               result_valid,
    input  wire                                result_stall,
    output logic signed [tlse_pkg::COORD_W-1:0] upper_x,
    output logic signed [tlse_pkg::COORD_W-1:0] upper_y,
    output logic signed [tlse_pkg::COORD_W-1:0] lower_x,
    output logic signed [tlse_pkg::COORD_W-1:0] lower_y,
    output logic                               saturated,
    output logic                               end_out,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [tlse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [tlse_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tlse_pkg::*;

    logic [WIDTH_W-1:0] line_width_reg;
    logic [STEP_W-1:0]  sample_step_reg;

    pipe_ctl_t ctl;
    logic      res_valid_reg;

    assign ctl.adv      = !(res_valid_reg && result_stall);
    assign sample_stall = !ctl.adv;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RESET;
            sample_step_reg <= SAMPLE_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_LINE_WIDTH)
                line_width_reg <= cfg_data[WIDTH_W-1:0];
            else if (cfg_index == REG_SAMPLE_STEP)
                sample_step_reg <= cfg_data[STEP_W-1:0];
        end
    end

    // stage 1: capture and form dy
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_px_reg, s1_py_reg;
    logic signed [COORD_W:0]   s1_dy_reg;
    logic                      s1_end_reg;

    // stage 2: normalize
    logic  s2_valid_reg;
    side_t s2_reg, s2_next;

    // stage 3: squares
    logic          s3_valid_reg;
    side_t         s3_reg;
    logic [61:0]   s3_aa_reg, s3_bb_reg;

    // stage 4: radicand
    logic             s4_valid_reg;
    side_t            s4_reg;
    logic [RAD_W-1:0] s4_rad_reg;

    // square root delay line
    logic  sq_valid_reg [SQ_STAGES];
    side_t sq_side_reg  [SQ_STAGES];
    logic [LEN_W-1:0] root;

    // stage M: width products
    logic             m_valid_reg;
    side_t            m_reg;
    logic [53:0]      m_px_reg, m_py_reg;
    logic [LEN_W-1:0] m_len_reg;

    // stage A: numerators
    logic             a_valid_reg;
    side_t            a_reg;
    logic [NUM_W-1:0] a_nx_reg, a_ny_reg;
    logic [DEN_W-1:0] a_den_reg;

    // divider delay line
    logic  dv_valid_reg [DIV_STAGES];
    side_t dv_side_reg  [DIV_STAGES];
    logic [QUO_W-1:0] magx, magy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < SQ_STAGES; i++)
                sq_valid_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                dv_valid_reg[i] <= 1'b0;
        end
        else if (ctl.adv)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            sq_valid_reg[0] <= s4_valid_reg;
            for (int i = 1; i < SQ_STAGES; i++)
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            m_valid_reg <= sq_valid_reg[SQ_STAGES-1];
            a_valid_reg <= m_valid_reg;
            dv_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            res_valid_reg <= dv_valid_reg[DIV_STAGES-1];
        end
    end

    always_comb
    begin
        logic [COORD_W-1:0] bmag;
        logic [STEP_W-1:0]  ar, br, v;
        logic [4:0]         msb, shamt;
        bmag = s1_dy_reg[COORD_W] ? COORD_W'(-s1_dy_reg) : s1_dy_reg[COORD_W-1:0];
        if (bmag[COORD_W-1])
        begin
            ar = sample_step_reg >> 1;
            br = bmag[COORD_W-1:1];
        end
        else
        begin
            ar = sample_step_reg;
            br = bmag[STEP_W-1:0];
        end
        v   = ar | br;
        msb = 5'd0;
        for (int i = 0; i < STEP_W; i++)
            if (v[i])
                msb = 5'(i);
        shamt        = 5'(STEP_W - 1) - msb;
        s2_next.px   = s1_px_reg;
        s2_next.py   = s1_py_reg;
        s2_next.dpos = !s1_dy_reg[COORD_W] && (s1_dy_reg != '0);
        s2_next.zero = (sample_step_reg == '0) && (s1_dy_reg == '0);
        s2_next.endm = s1_end_reg;
        s2_next.a    = ar << shamt;
        s2_next.b    = br << shamt;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            s1_px_reg  <= x_pos;
            s1_py_reg  <= y_here;
            s1_dy_reg  <= (COORD_W+1)'(y_next) - (COORD_W+1)'(y_here);
            s1_end_reg <= end_of_plot;
            s2_reg     <= s2_next;
            s3_reg     <= s2_reg;
            s3_aa_reg  <= 62'(s2_reg.a) * 62'(s2_reg.a);
            s3_bb_reg  <= 62'(s2_reg.b) * 62'(s2_reg.b);
            s4_reg     <= s3_reg;
            s4_rad_reg <= RAD_W'(s3_aa_reg) + RAD_W'(s3_bb_reg);
            sq_side_reg[0] <= s4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
            m_reg     <= sq_side_reg[SQ_STAGES-1];
            m_len_reg <= root;
            m_px_reg  <= 54'(line_width_reg) * 54'(sq_side_reg[SQ_STAGES-1].b);
            m_py_reg  <= 54'(line_width_reg) * 54'(sq_side_reg[SQ_STAGES-1].a);
            a_reg     <= m_reg;
            a_nx_reg  <= NUM_W'(m_px_reg) + NUM_W'(m_len_reg);
            a_ny_reg  <= NUM_W'(m_py_reg) + NUM_W'(m_len_reg);
            a_den_reg <= {m_len_reg, 1'b0};
            dv_side_reg[0] <= a_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    tlse_sqrt u_sqrt (
        .clk      (clk),
        .ctl      (ctl),
        .radicand (s4_rad_reg),
        .root     (root)
    );

    tlse_div u_div_x (
        .clk   (clk),
        .ctl   (ctl),
        .numer (a_nx_reg),
        .denom (a_den_reg),
        .quot  (magx)
    );

    tlse_div u_div_y (
        .clk   (clk),
        .ctl   (ctl),
        .numer (a_ny_reg),
        .denom (a_den_reg),
        .quot  (magy)
    );

    // clamp to 32 bits; top bit of the result flags a clamp
    function automatic logic [COORD_W:0] clamp32(input logic signed [COORD_W+2:0] v);
        logic [COORD_W:0] r;
        if (v > (COORD_W+3)'(signed'(32'sh7FFF_FFFF)))
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < (COORD_W+3)'(signed'(32'sh8000_0000)))
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[COORD_W-1:0]};
        return r;
    endfunction

    side_t            fin;
    logic signed [COORD_W+2:0] ox, oy;
    logic [COORD_W:0] ux_c, uy_c, lx_c, ly_c;

    always_comb
    begin
        fin = dv_side_reg[DIV_STAGES-1];
        if (fin.zero)
        begin
            ox = '0;
            oy = '0;
        end
        else
        begin
            ox = fin.dpos ? -(COORD_W+3)'($signed({1'b0, magx}))
                          :  (COORD_W+3)'($signed({1'b0, magx}));
            oy = (COORD_W+3)'($signed({1'b0, magy}));
        end
        ux_c = clamp32((COORD_W+3)'(fin.px) + ox);
        uy_c = clamp32((COORD_W+3)'(fin.py) + oy);
        lx_c = clamp32((COORD_W+3)'(fin.px) - ox);
        ly_c = clamp32((COORD_W+3)'(fin.py) - oy);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            upper_x   <= ux_c[COORD_W-1:0];
            upper_y   <= uy_c[COORD_W-1:0];
            lower_x   <= lx_c[COORD_W-1:0];
            lower_y   <= ly_c[COORD_W-1:0];
            saturated <= ux_c[COORD_W] | uy_c[COORD_W] | lx_c[COORD_W] | ly_c[COORD_W];
            end_out   <= fin.endm;
        end
    end

    assign result_valid = res_valid_reg;
endmodule
`default_nettype wire

[src/tlse_checker.sv]
// Port-level checks of the extruder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tlse_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                sample_stall,
    input wire                                result_valid,
    input wire                                result_stall,
    input wire signed [tlse_pkg::COORD_W-1:0] upper_y,
    input wire signed [tlse_pkg::COORD_W-1:0] lower_y,
    input wire                                saturated
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // output stall freezes the input side
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("sample stall does not follow result stall");

    // the y offset is never negative
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !saturated |-> upper_y >= lower_y)
        else $error("upper vertex below lower vertex");
endmodule

bind thick_line_segment_extrude tlse_checker u_tlse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .upper_y      (upper_y),
    .lower_y      (lower_y),
    .saturated    (saturated)
);
`default_nettype wire
